FILE: hdl/wsnt_pkg.sv
// Package for the weight sorted neighbor table: command and status codes,
// the command word that goes through the queue, and the control state types.
// It depends on nothing else.
package wsnt_pkg;

   // Default sizes that the top level hands down as parameters.
   localparam int TABLE_DEPTH_DEF = 32;
   localparam int ID_BITS_DEF     = 16;
   // Largest number of result words that one best-N request may give.
   localparam int MAX_RESULTS     = 32;

   // Command codes on the request channel.
   localparam logic [2:0] CMD_ADD   = 3'd0;
   localparam logic [2:0] CMD_ERASE = 3'd1;
   localparam logic [2:0] CMD_GET   = 3'd2;
   localparam logic [2:0] CMD_BEST  = 3'd3;
   localparam logic [2:0] CMD_CLEAR = 3'd4;

   // Status codes on the response channel.
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_SELF      = 3'd1;
   localparam logic [2:0] STAT_UNCHANGED = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
   localparam logic [2:0] STAT_EMPTY     = 3'd5;

   // Operation after classification by the front end.
   typedef enum logic [2:0] {
      OP_ADD,
      OP_SELF,
      OP_ERASE,
      OP_GET,
      OP_BEST,
      OP_CLEAR
   } wsnt_op_type;

   // Command word carried from the front end to the back end.
   typedef struct packed {
      wsnt_op_type op;
      logic [15:0] weight;
      logic [5:0]  count;
   } wsnt_cmd_type;

   // Back end sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE,
      ST_BEST
   } wsnt_state_type;

   // What a table cell loads on a commit.
   typedef enum logic [1:0] {
      CELL_KEEP,
      CELL_NEW,
      CELL_FROM_DN,
      CELL_FROM_UP
   } wsnt_cell_type;

endpackage

FILE: hdl/weight_sorted_neighbor_table.sv
// Weight sorted neighbor table: keeps up to TABLE_DEPTH (id, weight) pairs in
// descending weight order, stable among equal weights, and answers add, erase,
// get weight, best-N and clear requests. A front end classifies each request
// word into a two-word queue, so new words are taken while the back end works.
// The back end scans the table one entry per cycle through a single read port:
// add, erase and get go through take, scan and commit; clear and an add of the
// own id go through take and commit; best N gives one response word per cycle
// while the response side keeps up, or a single empty word when the answer is
// empty. Undefined command codes are taken and give no response. Depends on
// wsnt_pkg, wsnt_front, wsnt_queue and wsnt_back.
module weight_sorted_neighbor_table import wsnt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int ID_BITS     = ID_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [15:0] req_neighbor_id,
   input  logic [15:0] req_edge_weight,
   input  logic [5:0]  req_count_requested,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_result_id,
   output logic [15:0] rsp_result_weight,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int QW = $bits(wsnt_cmd_type) + ID_BITS;

   logic               fq_valid, fq_ready;
   wsnt_cmd_type       fq_cmd;
   logic [ID_BITS-1:0] fq_id;
   logic               qb_valid, qb_ready;
   logic [QW-1:0]      qb_data;
   wsnt_cmd_type       qb_cmd;
   logic [ID_BITS-1:0] qb_id;

   // Front end: own id register and classification.
   wsnt_front #(
      .ID_BITS (ID_BITS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_neighbor_id     (req_neighbor_id),
      .req_edge_weight     (req_edge_weight),
      .req_count_requested (req_count_requested),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .q_valid             (fq_valid),
      .q_ready             (fq_ready),
      .q_cmd               (fq_cmd),
      .q_id                (fq_id)
   );

   // Queue between the two halves.
   wsnt_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   ({fq_cmd, fq_id}),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   assign qb_cmd = wsnt_cmd_type'(qb_data[QW-1:ID_BITS]);
   assign qb_id  = qb_data[ID_BITS-1:0];

   // Back end: table, sequencer and response register.
   wsnt_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (qb_valid),
      .q_ready           (qb_ready),
      .q_cmd             (qb_cmd),
      .q_id              (qb_id),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_id     (rsp_result_id),
      .rsp_result_weight (rsp_result_weight),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

endmodule

FILE: hdl/wsnt_front.sv
// Front end of the neighbor table: holds the own id register, classifies each
// request word into an operation and drops undefined commands.
// Depends on wsnt_pkg.
module wsnt_front import wsnt_pkg::*; #(
   parameter int ID_BITS = ID_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_command,
   input  logic [15:0]        req_neighbor_id,
   input  logic [15:0]        req_edge_weight,
   input  logic [5:0]         req_count_requested,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data,
   output logic               q_valid,
   input  logic               q_ready,
   output wsnt_cmd_type       q_cmd,
   output logic [ID_BITS-1:0] q_id
);

   logic [15:0]        own_id_ff;
   logic [15:0]        own_id_in;
   logic [ID_BITS-1:0] id_masked;
   logic [ID_BITS-1:0] own_masked;
   logic               known;
   wsnt_op_type        op;

   // Own id register, written whenever the enable is high.
   always_comb begin
      own_id_in = csr_wr_en ? csr_wr_data : own_id_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= '0;
      end else begin
         own_id_ff <= own_id_in;
      end
   end

   // Ids are compared and stored at the table's id width.
   assign id_masked  = ID_BITS'(req_neighbor_id);
   assign own_masked = ID_BITS'(own_id_ff);

   // Classify the command; an add naming the own id is marked for a direct answer.
   always_comb begin
      known = 1'b1;
      op    = OP_ADD;
      unique case (req_command)
         CMD_ADD:   op = (id_masked == own_masked) ? OP_SELF : OP_ADD;
         CMD_ERASE: op = OP_ERASE;
         CMD_GET:   op = OP_GET;
         CMD_BEST:  op = OP_BEST;
         CMD_CLEAR: op = OP_CLEAR;
         default:   known = 1'b0;
      endcase
   end

   // Undefined commands are taken at once and never reach the queue.
   assign q_valid   = req_valid && known;
   assign req_ready = q_ready || !known;

   assign q_cmd.op     = op;
   assign q_cmd.weight = req_edge_weight;
   assign q_cmd.count  = req_count_requested;
   assign q_id         = id_masked;

endmodule

FILE: hdl/wsnt_queue.sv
// Two-word queue between the front end and the back end of the neighbor table.
// Depends on wsnt_pkg only through the common import.
module wsnt_queue import wsnt_pkg::*; #(
   parameter int WIDTH = $bits(wsnt_cmd_type) + ID_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push, pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage words need no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

FILE: hdl/wsnt_back.sv
// Back end of the neighbor table: the sorted table cells, the scan and commit
// sequencer, and the response register. Depends on wsnt_pkg.
module wsnt_back import wsnt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int ID_BITS     = ID_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  wsnt_cmd_type       q_cmd,
   input  logic [ID_BITS-1:0] q_id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_result_id,
   output logic [15:0]        rsp_result_weight,
   output logic [2:0]         rsp_status,
   output logic               rsp_last
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int NW    = (CNT_W > 6) ? CNT_W : 6;

   wsnt_state_type     state_ff, state_in;
   wsnt_cmd_type       cmd_ff, cmd_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic               found_ff, found_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [15:0]        fw_ff, fw_in;
   logic [CNT_W-1:0]   p_ff, p_in;
   logic [NW-1:0]      k_ff, k_in;
   logic [NW-1:0]      n_ff, n_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic [ID_BITS-1:0] ids_ff [TABLE_DEPTH];
   logic [15:0]        wts_ff [TABLE_DEPTH];

   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_id_ff, rsp_id_in;
   logic [15:0]        rsp_w_ff, rsp_w_in;
   logic [2:0]         rsp_st_ff, rsp_st_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [IDX_W-1:0]   rd_idx;
   logic [ID_BITS-1:0] rd_id;
   logic [15:0]        rd_w;
   logic               out_free;
   logic               scan_end;
   logic [5:0]         req_sat;
   logic [NW-1:0]      n_sel;
   logic               best_last;
   logic               add_unch;
   logic               add_full;
   logic               do_insert;
   logic               do_remove;
   logic               done_fire;
   logic [CNT_W-1:0]   ins_at;

   // One read port into the table, shared by the scan and best-N emission.
   assign rd_idx = (state_ff == ST_BEST) ? k_ff[IDX_W-1:0] : i_ff[IDX_W-1:0];
   assign rd_id  = ids_ff[rd_idx];
   assign rd_w   = wts_ff[rd_idx];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign scan_end  = (i_ff == count_ff);
   assign req_sat   = (q_cmd.count > 6'(MAX_RESULTS)) ? 6'(MAX_RESULTS) : q_cmd.count;
   assign n_sel     = (NW'(count_ff) < NW'(req_sat)) ? NW'(count_ff) : NW'(req_sat);
   assign best_last = ((k_ff + NW'(1)) == n_ff);

   // Commit decisions, taken in the done state once the response slot is free.
   assign done_fire = (state_ff == ST_DONE) && out_free;
   assign add_unch  = found_ff && (fw_ff == cmd_ff.weight);
   assign add_full  = !found_ff && (count_ff == CNT_W'(TABLE_DEPTH));
   assign do_insert = done_fire && (cmd_ff.op == OP_ADD) && !add_unch && !add_full;
   assign do_remove = done_fire && (cmd_ff.op == OP_ERASE) && found_ff;
   assign ins_at    = found_ff ? idx_ff : count_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.op)
                  OP_SELF, OP_CLEAR: state_in = ST_DONE;
                  OP_BEST:           state_in = (n_sel == '0) ? ST_DONE : ST_BEST;
                  default:           state_in = ST_SCAN;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_end) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_BEST: begin
            if (out_free && best_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer toward the queue.
   always_comb begin
      q_ready = (state_ff == ST_IDLE);
   end

   // Held command, scan bookkeeping and emission counter.
   always_comb begin
      cmd_in   = cmd_ff;
      id_in    = id_ff;
      i_in     = i_ff;
      found_in = found_ff;
      idx_in   = idx_ff;
      fw_in    = fw_ff;
      p_in     = p_ff;
      k_in     = k_ff;
      n_in     = n_ff;
      if (state_ff == ST_IDLE && q_valid) begin
         cmd_in   = q_cmd;
         id_in    = q_id;
         i_in     = '0;
         found_in = 1'b0;
         idx_in   = '0;
         fw_in    = '0;
         p_in     = '0;
         k_in     = '0;
         n_in     = n_sel;
      end else if (state_ff == ST_SCAN && !scan_end) begin
         // Count the entries that end up ahead of the new weight in a stable order.
         i_in = i_ff + CNT_W'(1);
         if (rd_id == id_ff) begin
            found_in = 1'b1;
            idx_in   = i_ff;
            fw_in    = rd_w;
         end else if (found_ff ? (rd_w > cmd_ff.weight) : (rd_w >= cmd_ff.weight)) begin
            p_in = p_ff + CNT_W'(1);
         end
      end else if (state_ff == ST_BEST && out_free) begin
         k_in = k_ff + NW'(1);
      end
   end

   // Fill count.
   always_comb begin
      count_in = count_ff;
      if (do_insert && !found_ff) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_remove) begin
         count_in = count_ff - CNT_W'(1);
      end else if (done_fire && cmd_ff.op == OP_CLEAR) begin
         count_in = '0;
      end
   end

   // Response register: holds a word until it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_id_in    = rsp_id_ff;
      rsp_w_in     = rsp_w_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_last_in  = rsp_last_ff;
      if (done_fire) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         rsp_id_in    = 16'(id_ff);
         rsp_w_in     = 16'd0;
         rsp_st_in    = STAT_OK;
         unique case (cmd_ff.op)
            OP_SELF: begin
               rsp_w_in  = cmd_ff.weight;
               rsp_st_in = STAT_SELF;
            end
            OP_ADD: begin
               rsp_w_in = cmd_ff.weight;
               if (add_unch) begin
                  rsp_st_in = STAT_UNCHANGED;
               end else if (add_full) begin
                  rsp_st_in = STAT_FULL;
               end
            end
            OP_ERASE, OP_GET: begin
               rsp_w_in  = found_ff ? fw_ff : 16'd0;
               rsp_st_in = found_ff ? STAT_OK : STAT_NOT_FOUND;
            end
            OP_BEST: begin
               rsp_id_in = 16'd0;
               rsp_st_in = STAT_EMPTY;
            end
            default: begin
               rsp_st_in = STAT_OK;
            end
         endcase
      end else if (state_ff == ST_BEST && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = 16'(rd_id);
         rsp_w_in     = rd_w;
         rsp_st_in    = STAT_OK;
         rsp_last_in  = best_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      i_ff        <= i_in;
      found_ff    <= found_in;
      idx_ff      <= idx_in;
      fw_ff       <= fw_in;
      p_ff        <= p_in;
      k_ff        <= k_in;
      n_ff        <= n_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_w_ff    <= rsp_w_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Table cells. A commit removes the old place of the entry and inserts it
   // at its new place in one step; each cell loads from itself or a neighbor.
   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      localparam logic [CNT_W-1:0] KK = CNT_W'(k);
      logic [ID_BITS-1:0] up_id, dn_id;
      logic [15:0]        up_w, dn_w;
      wsnt_cell_type      sel;

      if (k == 0) begin : g_bottom
         assign dn_id = '0;
         assign dn_w  = '0;
      end else begin : g_dn
         assign dn_id = ids_ff[k-1];
         assign dn_w  = wts_ff[k-1];
      end

      if (k == TABLE_DEPTH - 1) begin : g_top
         assign up_id = '0;
         assign up_w  = '0;
      end else begin : g_up
         assign up_id = ids_ff[k+1];
         assign up_w  = wts_ff[k+1];
      end

      always_comb begin
         sel = CELL_KEEP;
         if (do_insert) begin
            if (p_ff <= ins_at) begin
               if (KK == p_ff) begin
                  sel = CELL_NEW;
               end else if (KK > p_ff && KK <= ins_at) begin
                  sel = CELL_FROM_DN;
               end
            end else begin
               if (KK == p_ff) begin
                  sel = CELL_NEW;
               end else if (KK >= ins_at && KK < p_ff) begin
                  sel = CELL_FROM_UP;
               end
            end
         end else if (do_remove && KK >= idx_ff) begin
            sel = CELL_FROM_UP;
         end
      end

      always_ff @(posedge clock) begin
         unique case (sel)
            CELL_KEEP: begin
            end
            CELL_NEW: begin
               ids_ff[k] <= id_ff;
               wts_ff[k] <= cmd_ff.weight;
            end
            CELL_FROM_DN: begin
               ids_ff[k] <= dn_id;
               wts_ff[k] <= dn_w;
            end
            CELL_FROM_UP: begin
               ids_ff[k] <= up_id;
               wts_ff[k] <= up_w;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_id     = rsp_id_ff;
   assign rsp_result_weight = rsp_w_ff;
   assign rsp_status        = rsp_st_ff;
   assign rsp_last          = rsp_last_ff;

   // The fill count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // A found entry always lies inside the filled part of the table.
   a_found_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && found_ff) |-> (idx_ff < count_ff))
      else $error("found index outside the table");

   // The insert position never lies past the filled part.
   a_insert_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (p_ff <= count_ff))
      else $error("insert position past the fill count");

   // Best-N emission stays below its word count and ends after the last word.
   a_best_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BEST) |-> (k_ff < n_ff))
      else $error("best-N index past its word count");

   a_best_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BEST && out_free && best_last) |=>
         (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("best-N did not end on its last word");

endmodule

FILE: tb/sv/tb_weight_sorted_neighbor_table.sv
// Testbench for the weight sorted neighbor table: drives request words with
// random gaps, predicts every response word with its own sorted table model
// and checks each response in order. Depends on wsnt_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_weight_sorted_neighbor_table;
   import wsnt_pkg::*;

   // One response word as the table should give it.
   typedef struct {
      logic [15:0] id;
      logic [15:0] weight;
      logic [2:0]  status;
      logic        last;
   } nbr_rsp_type;

   // Sorted neighbor table predictor with its queue of pending response words.
   class neighbor_scoreboard;
      logic [15:0] ids[32];
      logic [15:0] weights[32];
      int          count;
      logic [15:0] self_id;
      nbr_rsp_type pending[$];
      int          mismatches;
      int          checked;

      function void clear_all();
         count = 0;
         self_id = 0;
         pending.delete();
         mismatches = 0;
         checked = 0;
      endfunction

      function void push(logic [15:0] id, logic [15:0] w, logic [2:0] st, logic lst);
         nbr_rsp_type r;
         r.id = id;
         r.weight = w;
         r.status = st;
         r.last = lst;
         pending.push_back(r);
      endfunction

      function int find(logic [15:0] id);
         for (int i = 0; i < count; i++)
            if (ids[i] == id) return i;
         return -1;
      endfunction

      // Stable insertion pass: entries move only past strictly smaller weights.
      function void resort();
         logic [15:0] w;
         logic [15:0] id;
         int j;
         for (int i = 1; i < count; i++) begin
            w = weights[i];
            id = ids[i];
            j = i;
            while (j > 0 && weights[j-1] < w) begin
               weights[j] = weights[j-1];
               ids[j] = ids[j-1];
               j--;
            end
            weights[j] = w;
            ids[j] = id;
         end
      endfunction

      // Notes an accepted request word and queues the responses it causes.
      function void note_request(logic [2:0] cmd, logic [15:0] id, logic [15:0] w,
                                 logic [5:0] n_req);
         int idx;
         int n;
         case (cmd)
            CMD_ADD: begin
               if (id == self_id) push(id, w, STAT_SELF, 1);
               else begin
                  idx = find(id);
                  if (idx >= 0 && weights[idx] == w) push(id, w, STAT_UNCHANGED, 1);
                  else if (idx < 0 && count >= 32) push(id, w, STAT_FULL, 1);
                  else begin
                     if (idx >= 0) weights[idx] = w;
                     else begin
                        ids[count] = id;
                        weights[count] = w;
                        count++;
                     end
                     resort();
                     push(id, w, STAT_OK, 1);
                  end
               end
            end
            CMD_ERASE: begin
               idx = find(id);
               if (idx < 0) push(id, 0, STAT_NOT_FOUND, 1);
               else begin
                  push(id, weights[idx], STAT_OK, 1);
                  for (int i = idx; i + 1 < count; i++) begin
                     ids[i] = ids[i+1];
                     weights[i] = weights[i+1];
                  end
                  count--;
               end
            end
            CMD_GET: begin
               idx = find(id);
               if (idx < 0) push(id, 0, STAT_NOT_FOUND, 1);
               else push(id, weights[idx], STAT_OK, 1);
            end
            CMD_BEST: begin
               n = (count < n_req) ? count : n_req;
               if (n > MAX_RESULTS) n = MAX_RESULTS;
               if (n == 0) push(0, 0, STAT_EMPTY, 1);
               else
                  for (int k = 0; k < n; k++) push(ids[k], weights[k], STAT_OK, k + 1 == n);
            end
            CMD_CLEAR: begin
               count = 0;
               push(id, 0, STAT_OK, 1);
            end
            default: ;
         endcase
      endfunction

      // Compares one accepted response word with the oldest expectation.
      function void check_response(logic [15:0] id, logic [15:0] w, logic [2:0] st,
                                   logic lst);
         nbr_rsp_type e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word id=%h weight=%h status=%0d last=%0b",
                        id, w, st, lst);
            return;
         end
         e = pending.pop_front();
         if (e.id !== id || e.weight !== w || e.status !== st || e.last !== lst) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected id=%h weight=%h status=%0d last=%0b, %s",
                        e.id, e.weight, e.status, e.last,
                        $sformatf("got id=%h weight=%h status=%0d last=%0b", id, w, st, lst));
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_command;
   logic [15:0] req_neighbor_id;
   logic [15:0] req_edge_weight;
   logic [5:0]  req_count_requested;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_result_id;
   logic [15:0] rsp_result_weight;
   logic [2:0]  rsp_status;
   logic        rsp_last;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   neighbor_scoreboard board;
   int  cycles;
   int  words_sent;
   bit  stall_free;
   logic [15:0] id_pool[8];

   localparam int CYCLE_LIMIT = 400000;

   weight_sorted_neighbor_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_neighbor_id(req_neighbor_id), .req_edge_weight(req_edge_weight),
      .req_count_requested(req_count_requested),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_result_id(rsp_result_id),
      .rsp_result_weight(rsp_result_weight), .rsp_status(rsp_status),
      .rsp_last(rsp_last), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Cycle counter with the run limit.
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Response side: check accepted words at the rising edge, stall at random.
   initial begin
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            board.check_response(rsp_result_id, rsp_result_weight, rsp_status, rsp_last);
         @(negedge clock);
         rsp_ready <= stall_free || ($urandom_range(99) >= 22);
      end
   end

   // Sends one request word and notes it once accepted. Valid stays high
   // into the next word unless that word starts with an idle gap or a drain.
   task automatic send_word(logic [2:0] cmd, logic [15:0] id, logic [15:0] w,
                            logic [5:0] n);
      while (!stall_free && $urandom_range(99) < 22) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_neighbor_id <= id;
      req_edge_weight <= w;
      req_count_requested <= n;
      do @(posedge clock); while (!req_ready);
      board.note_request(cmd, id, w, n);
      words_sent++;
      @(negedge clock);
   endtask

   // Waits until every expected word has come, then lets the block settle.
   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_own_id(logic [15:0] v);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 0;
      board.self_id = v;
   endtask

   // Random word, mostly on a small id pool so that updates and erases hit.
   task automatic random_word();
      int sel;
      logic [15:0] id;
      logic [15:0] w;
      sel = $urandom_range(99);
      id = ($urandom_range(9) < 8) ? id_pool[$urandom_range(7)] : 16'($urandom);
      w = ($urandom_range(1)) ? 16'($urandom_range(15)) : 16'($urandom);
      if (sel < 45) send_word(CMD_ADD, id, w, 6'($urandom));
      else if (sel < 60) send_word(CMD_ERASE, id, w, 6'($urandom));
      else if (sel < 72) send_word(CMD_GET, id, w, 6'($urandom));
      else if (sel < 92) send_word(CMD_BEST, id, w, 6'($urandom_range(40)));
      else if (sel < 95) send_word(CMD_CLEAR, id, w, 6'($urandom));
      else send_word(3'($urandom_range(7, 5)), id, w, 6'($urandom));
   endtask

   initial begin
      board = new();
      board.clear_all();
      stall_free = 0;
      words_sent = 0;
      reset = 1;
      req_valid = 0;
      req_command = CMD_ADD;
      req_neighbor_id = 0;
      req_edge_weight = 0;
      req_count_requested = 0;
      csr_wr_en = 0;
      csr_wr_data = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed part: empty answers, self id, extremes, fill to full.
      send_word(CMD_BEST, 0, 0, 6'd5);
      send_word(CMD_ADD, 16'h0000, 16'd7, 0);
      write_own_id(16'hFFFF);
      send_word(CMD_ADD, 16'hFFFF, 16'd9, 0);
      send_word(CMD_ADD, 16'h0000, 16'hFFFF, 0);
      send_word(CMD_ADD, 16'h1234, 16'd0, 0);
      send_word(CMD_ADD, 16'h5678, 16'd0, 0);
      send_word(CMD_ADD, 16'h1234, 16'd0, 0);
      send_word(CMD_ADD, 16'h5678, 16'd100, 0);
      send_word(CMD_BEST, 0, 0, 6'd0);
      send_word(CMD_BEST, 0, 0, 6'd63);
      send_word(CMD_GET, 16'h5678, 0, 0);
      send_word(CMD_GET, 16'hAAAA, 0, 0);
      send_word(CMD_ERASE, 16'h1234, 0, 0);
      send_word(CMD_ERASE, 16'h1234, 0, 0);
      send_word(3'd5, 0, 0, 0);
      send_word(3'd7, 16'hFFFF, 16'hFFFF, 6'h3F);
      for (int i = 0; i < 32; i++) send_word(CMD_ADD, 16'(16'h0100 + i), 16'(i % 4), 0);
      send_word(CMD_ADD, 16'h0100, 16'd50, 0);
      send_word(CMD_BEST, 0, 0, 6'd32);
      send_word(CMD_CLEAR, 16'hBEEF, 0, 0);
      send_word(CMD_BEST, 0, 0, 6'd1);

      // Random part in phases with different own ids.
      for (int phase = 0; phase < 4; phase++) begin
         write_own_id(phase == 1 ? 16'h0000 : 16'($urandom));
         for (int i = 0; i < 8; i++) id_pool[i] = 16'($urandom);
         id_pool[7] = board.self_id;
         stall_free = (phase == 2);
         for (int i = 0; i < 100; i++) begin
            random_word();
            if (i == 50) drain();
         end
      end
      stall_free = 0;

      drain();
      $display("sent %0d request words, checked %0d response words in %0d cycles",
               words_sent, board.checked, cycles);
      $display("covered add, update, self id, full table, erase, lookup, best N and clear");
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
